// ===== rtl/core/cpr_pkg.sv =====
// Shared constants and IEEE single multiply and add helpers for the complex plane rotation.
package cpr_pkg;

  localparam logic [31:0] COS_RESET = 32'h3F80_0000;
  localparam logic [31:0] SIN_RESET = 32'h0000_0000;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic        REG_COS   = 1'b0;
  localparam logic        REG_SIN   = 1'b1;

  // Partial product state: sign, biased exponent, 48-bit significand product.
  typedef struct packed {
    logic        sgn;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic signed [10:0] exp;
    logic [47:0] sig;
  } mul_raw_t;

  // Leading zero count of a 48-bit word, 48 when the word is zero.
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       hit;
    n = 6'd48;
    hit = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n = 6'(47 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Leading zero count of a 28-bit word, 28 when the word is zero.
  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    logic       hit;
    n = 5'd28;
    hit = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n = 5'(27 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Multiply front end: unpack and form the significand product.
  function automatic mul_raw_t fmul_raw(input logic [31:0] a, input logic [31:0] b);
    mul_raw_t    r;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic        a_zero;
    logic        b_zero;
    ea = a[30:23];
    eb = b[30:23];
    ma = {(ea != 8'd0), a[22:0]};
    mb = {(eb != 8'd0), b[22:0]};
    a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    r.sgn = a[31] ^ b[31];
    r.is_nan = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    r.is_inf = a_inf || b_inf;
    r.is_zero = a_zero || b_zero;
    // Exponent of the product's bit 46; subnormals use exponent 1.
    r.exp = 11'(signed'({3'b000, (ea == 8'd0) ? 8'd1 : ea}))
          + 11'(signed'({3'b000, (eb == 8'd0) ? 8'd1 : eb})) - 11'sd127;
    r.sig = ma * mb;
    return r;
  endfunction

  // Round a positive value sig[47:0] with bit 46 weighted 2^(exp-127) to single.
  function automatic logic [31:0] fpack(input logic sgn, input logic signed [11:0] exp,
                                        input logic [47:0] sig);
    logic [5:0]         lz;
    logic [47:0]        nm;
    logic signed [11:0] e;
    logic [5:0]         sh;
    logic [48:0]        w;
    logic [23:0]        kept;
    logic               g;
    logic               st;
    logic [24:0]        rnd;
    logic [8:0]         eo;
    lz = lzc48(sig);
    nm = sig << lz;
    // nm[47] has exponent e (biased).
    e = exp + 12'sd1 - 12'(signed'({6'd0, lz}));
    if (sig == 48'd0) begin
      return {sgn, 31'd0};
    end
    if (e < 12'sd1) begin
      sh = (e < -12'sd30) ? 6'd31 : 6'(12'sd1 - e);
      w = {nm, 1'b0} >> sh;
      st = |({nm, 1'b0} & ~({49{1'b1}} << sh));
      e = 12'sd0;
    end else begin
      w = {nm, 1'b0};
      st = 1'b0;
    end
    kept = w[48:25];
    g = w[24];
    st = st | (|w[23:0]);
    rnd = {1'b0, kept} + 25'(g && (st || kept[0]));
    if (e == 12'sd0) begin
      // Subnormal: bit 23 of the rounded word marks a carry into the normal range.
      return {sgn, 8'(rnd[23]), rnd[22:0]};
    end
    if (rnd[24]) begin
      eo = 9'(e) + 9'd1;
      rnd = rnd >> 1;
    end else begin
      eo = 9'(e);
    end
    if (e > 12'sd254 || eo > 9'd254) begin
      return {sgn, 8'hFF, 23'd0};
    end
    return {sgn, eo[7:0], rnd[22:0]};
  endfunction

  // Unpacked addend for the adder stages.
  typedef struct packed {
    logic        sgn;
    logic [7:0]  exp;
    logic [23:0] man;
    logic        is_nan;
    logic        is_inf;
  } add_op_t;

  function automatic add_op_t unpack(input logic [31:0] a);
    add_op_t r;
    r.sgn = a[31];
    r.exp = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    r.man = {(a[30:23] != 8'd0), a[22:0]};
    r.is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    r.is_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    return r;
  endfunction

  // Aligned operands after the swap and shift stage.
  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic        sgn_big;
    logic        sgn_small;
    logic        both_zero_neg;
    logic [7:0]  exp;
    logic [26:0] big;
    logic [26:0] minor;
  } add_al_t;

  function automatic add_al_t add_align(input logic [31:0] a, input logic [31:0] b);
    add_al_t     r;
    add_op_t     pa;
    add_op_t     pb;
    add_op_t     hi;
    add_op_t     lo;
    logic [7:0]  d;
    logic [49:0] sh;
    pa = unpack(a);
    pb = unpack(b);
    r.special = 1'b0;
    r.spec_val = 32'd0;
    if (pa.is_nan || pb.is_nan || (pa.is_inf && pb.is_inf && (pa.sgn != pb.sgn))) begin
      r.special = 1'b1;
      r.spec_val = CANON_NAN;
    end else if (pa.is_inf) begin
      r.special = 1'b1;
      r.spec_val = a;
    end else if (pb.is_inf) begin
      r.special = 1'b1;
      r.spec_val = b;
    end
    r.both_zero_neg = a[31] && b[31];
    if ({pa.exp, pa.man} >= {pb.exp, pb.man}) begin
      hi = pa;
      lo = pb;
    end else begin
      hi = pb;
      lo = pa;
    end
    d = hi.exp - lo.exp;
    sh = {lo.man, 26'd0} >> ((d > 8'd27) ? 8'd27 : d);
    r.sgn_big = hi.sgn;
    r.sgn_small = lo.sgn;
    r.exp = hi.exp;
    r.big = {hi.man, 3'b000};
    r.minor = {sh[49:24], |sh[23:0]};
    return r;
  endfunction

  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic        sgn;
    logic        zero_neg;
    logic [7:0]  exp;
    logic [27:0] sum;
  } add_sum_t;

  function automatic add_sum_t add_sum(input add_al_t a);
    add_sum_t r;
    r.special = a.special;
    r.spec_val = a.spec_val;
    r.sgn = a.sgn_big;
    r.exp = a.exp;
    if (a.sgn_big == a.sgn_small) begin
      r.sum = {1'b0, a.big} + {1'b0, a.minor};
    end else begin
      r.sum = {1'b0, a.big} - {1'b0, a.minor};
    end
    r.zero_neg = a.both_zero_neg;
    return r;
  endfunction

  // Normalize, round and pack the sum.
  function automatic logic [31:0] add_final(input add_sum_t a);
    logic [4:0]         lz;
    logic [27:0]        nm;
    logic signed [11:0] e;
    logic [5:0]         sh;
    logic [27:0]        w;
    logic [23:0]        kept;
    logic               g;
    logic               st;
    logic [24:0]        rnd;
    logic [8:0]         eo;
    if (a.special) begin
      return a.spec_val;
    end
    if (a.sum == 28'd0) begin
      return {a.zero_neg, 31'd0};
    end
    lz = lzc28(a.sum);
    // sum[27] has weight of exponent exp+1.
    e = 12'(signed'({4'd0, a.exp})) + 12'sd1 - 12'(signed'({7'd0, lz}));
    if (e < 12'sd1) begin
      sh = 6'(12'(signed'({7'd0, lz})) - 12'sd1 + e);
      nm = a.sum << sh;
      e = 12'sd0;
    end else begin
      nm = a.sum << lz;
    end
    w = nm;
    kept = w[27:4];
    g = w[3];
    st = |w[2:0];
    rnd = {1'b0, kept} + 25'(g && (st || kept[0]));
    if (e == 12'sd0) begin
      return {a.sgn, 8'(rnd[23]), rnd[22:0]};
    end
    if (rnd[24]) begin
      eo = 9'(e) + 9'd1;
      rnd = rnd >> 1;
    end else begin
      eo = 9'(e);
    end
    if (eo > 9'd254) begin
      return {a.sgn, 8'hFF, 23'd0};
    end
    return {a.sgn, eo[7:0], rnd[22:0]};
  endfunction

endpackage

// ===== rtl/core/cpr_lane.sv =====
// One rotation lane: a*b + or - p*q with separately rounded products, five register stages.
module cpr_lane
  import cpr_pkg::*;
(
  input  logic        clk,
  input  logic        vld,
  input  logic        sub,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] p,
  input  logic [31:0] q,
  output logic [31:0] res
);

  mul_raw_t    m1_r;
  mul_raw_t    m2_r;
  logic        sub1_r;
  logic [31:0] r1_r;
  logic [31:0] r2_r;
  add_al_t     al_r;
  add_sum_t    sm_r;
  logic [31:0] res_r;
  logic [31:0] prod2;

  function automatic logic [31:0] mul_fin(input mul_raw_t m);
    if (m.is_nan) begin
      return CANON_NAN;
    end
    if (m.is_inf) begin
      return {m.sgn, 8'hFF, 23'd0};
    end
    if (m.is_zero) begin
      return {m.sgn, 31'd0};
    end
    return fpack(m.sgn, 12'(m.exp), m.sig);
  endfunction

  assign prod2 = mul_fin(m2_r);

  // Payload only; the valid bits travel in the top level.
  always_ff @(posedge clk) begin
    if (vld) begin
      m1_r <= fmul_raw(a, b);
      m2_r <= fmul_raw(p, q);
      sub1_r <= sub;
    end
    r1_r <= mul_fin(m1_r);
    r2_r <= sub1_r ? {~prod2[31], prod2[30:0]} : prod2;
    al_r <= add_align(r1_r, r2_r);
    sm_r <= add_sum(al_r);
    res_r <= add_final(sm_r);
  end

  assign res = res_r;

endmodule

// ===== rtl/core/complex_plane_rotation_top.sv =====
// Complex plane rotation: one item per cycle; out_valid follows start through the lane stages.
// Four lanes run in parallel; each has a multiply stage, a product rounding stage,
// an align stage, an add stage and a normalize and round stage.
// The receiver cannot stall, so busy stays low and every cycle may take an item.
// Synchronous active-low reset clears the valid pipeline and loads c = 1.0, s = 0.0.
module complex_plane_rotation_top
  import cpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_x_real,
  input  logic [31:0] in_x_imag,
  input  logic [31:0] in_y_real,
  input  logic [31:0] in_y_imag,
  input  logic        in_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [31:0] out_new_x_real,
  output logic [31:0] out_new_x_imag,
  output logic [31:0] out_new_y_real,
  output logic [31:0] out_new_y_imag,
  output logic        out_last
);

  localparam int unsigned DEPTH = 5;

  logic [31:0]      cos_r;
  logic [31:0]      sin_r;
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] last_r;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= COS_RESET;
      sin_r <= SIN_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index[0])
          REG_COS: cos_r <= cfg_data;
          REG_SIN: sin_r <= cfg_data;
          default: ;
        endcase
      end
      vld_r <= {vld_r[DEPTH-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    last_r <= {last_r[DEPTH-2:0], in_last};
  end

  cpr_lane u_xr (.clk, .vld(start), .sub(1'b0), .a(cos_r), .b(in_x_real),
                 .p(sin_r), .q(in_y_real), .res(out_new_x_real));
  cpr_lane u_xi (.clk, .vld(start), .sub(1'b0), .a(cos_r), .b(in_x_imag),
                 .p(sin_r), .q(in_y_imag), .res(out_new_x_imag));
  cpr_lane u_yr (.clk, .vld(start), .sub(1'b1), .a(cos_r), .b(in_y_real),
                 .p(sin_r), .q(in_x_real), .res(out_new_y_real));
  cpr_lane u_yi (.clk, .vld(start), .sub(1'b1), .a(cos_r), .b(in_y_imag),
                 .p(sin_r), .q(in_x_imag), .res(out_new_y_imag));

  assign out_valid = vld_r[DEPTH-1];
  assign out_last = last_r[DEPTH-1];

endmodule

// ===== tb/tb_complex_plane_rotation_top.sv =====
// Self-checking testbench for the complex plane rotation block, with an IEEE single predictor.
module tb_complex_plane_rotation_top
  import cpr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [31:0] x_re;
    logic [31:0] x_im;
    logic [31:0] y_re;
    logic [31:0] y_im;
    logic        last;
  } pair_t;

  class rotation_scoreboard;
    logic [31:0] cos_bits;
    logic [31:0] sin_bits;
    pair_t       rotated_q[$];
    int          errors;

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == REG_COS) cos_bits = val;
      else sin_bits = val;
    endfunction

    // Widen a single to a double; every single is exact as a double.
    function real widen(logic [31:0] b);
      logic [63:0] d;
      real         r;
      if (b[30:23] == 8'hFF) begin
        d = (b[22:0] != 0) ? 64'h7FF8_0000_0000_0000 : {b[31], 11'h7FF, 52'd0};
        return $bitstoreal(d);
      end
      if (b[30:0] == 0) return $bitstoreal({b[31], 63'd0});
      if (b[30:23] == 8'd0) begin
        r = real'(b[22:0]) * (2.0 ** -149);
        return b[31] ? -r : r;
      end
      d = {b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'd0};
      return $bitstoreal(d);
    endfunction

    // Round a double to single with round to nearest even, subnormals kept.
    function logic [31:0] narrow(real r);
      logic [63:0] d;
      logic [63:0] m;
      int          ex;
      int          sh;
      longint      kept;
      longint      res;
      bit          g;
      bit          st;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : {d[31 + 32], 8'hFF, 23'd0};
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      ex = int'(d[62:52]) - 1023 + 127;
      m = {11'd0, 1'b1, d[51:0]};
      sh = (ex >= 1) ? 29 : 30 - ex;
      if (sh > 63) sh = 63;
      kept = longint'(m >> sh);
      g = m[sh - 1];
      st = (m & ((64'd1 << (sh - 1)) - 1)) != 0;
      res = kept + ((g && (st || kept[0])) ? 1 : 0);
      if (ex >= 1) res = res + (longint'(ex - 1) << 23);
      if (res >= 64'h7F80_0000) return {d[63], 8'hFF, 23'd0};
      return {d[63], 31'(res)};
    endfunction

    // a*b +/- p*q, each product rounded on its own.
    function logic [31:0] rot_lane(logic [31:0] a, logic [31:0] b, logic [31:0] p,
                                   logic [31:0] q, bit subtract);
      real m1;
      real m2;
      m1 = widen(narrow(widen(a) * widen(b)));
      m2 = widen(narrow(widen(p) * widen(q)));
      return narrow(subtract ? m1 - m2 : m1 + m2);
    endfunction

    function void note_pair(pair_t in);
      pair_t e;
      e.x_re = rot_lane(cos_bits, in.x_re, sin_bits, in.y_re, 0);
      e.x_im = rot_lane(cos_bits, in.x_im, sin_bits, in.y_im, 0);
      e.y_re = rot_lane(cos_bits, in.y_re, sin_bits, in.x_re, 1);
      e.y_im = rot_lane(cos_bits, in.y_im, sin_bits, in.x_im, 1);
      e.last = in.last;
      rotated_q.push_back(e);
    endfunction

    function void check_result(pair_t got);
      pair_t e;
      if (rotated_q.size() == 0) begin
        $error("unexpected result item");
        errors++;
        return;
      end
      e = rotated_q.pop_front();
      if (got.x_re !== e.x_re) begin
        $error("new_x_real exp %h got %h", e.x_re, got.x_re); errors++;
      end
      if (got.x_im !== e.x_im) begin
        $error("new_x_imag exp %h got %h", e.x_im, got.x_im); errors++;
      end
      if (got.y_re !== e.y_re) begin
        $error("new_y_real exp %h got %h", e.y_re, got.y_re); errors++;
      end
      if (got.y_im !== e.y_im) begin
        $error("new_y_imag exp %h got %h", e.y_im, got.y_im); errors++;
      end
      if (got.last !== e.last) begin
        $error("out_last exp %b got %b", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_x_real = '0;
  logic [31:0] in_x_imag = '0;
  logic [31:0] in_y_real = '0;
  logic [31:0] in_y_imag = '0;
  logic        in_last = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        out_valid;
  logic [31:0] out_new_x_real;
  logic [31:0] out_new_x_imag;
  logic [31:0] out_new_y_real;
  logic [31:0] out_new_y_imag;
  logic        out_last;

  rotation_scoreboard sb = new();
  int cycles = 0;
  int idle_pct = 0;

  always #2 clk = ~clk;

  complex_plane_rotation_top u_dut (.*);

  always @(posedge clk) begin
    pair_t got;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n && out_valid) begin
      got.x_re = out_new_x_real;
      got.x_im = out_new_x_imag;
      got.y_re = out_new_y_real;
      got.y_im = out_new_y_imag;
      got.last = out_last;
      sb.check_result(got);
    end
  end

  // Special values weighted heavily so that rounding edges are hit often.
  function automatic logic [31:0] pick_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: v[30:0] = 31'd0;
      3: v[30:23] = 8'($urandom_range(1, 24));
      4: v[30:23] = 8'($urandom_range(230, 254));
      5: v[22:0] = ($urandom_range(0, 1) != 0) ? 23'h7FFFFF : 23'($urandom_range(0, 3));
      default: v[30:23] = 8'($urandom_range(110, 145));
    endcase
    return v;
  endfunction

  // Start stays high between back-to-back items; idle cycles and write_reg drop it.
  task automatic send_pair(pair_t p);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_x_real <= p.x_re;
    in_x_imag <= p.x_im;
    in_y_real <= p.y_re;
    in_y_imag <= p.y_im;
    in_last <= p.last;
    do @(posedge clk); while (busy);
    sb.note_pair(p);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    start <= 1'b0;
    // Let the pipeline empty before the coefficients change.
    while (sb.rotated_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(int n);
    pair_t p;
    for (int i = 0; i < n; i++) begin
      p.x_re = pick_float();
      p.x_im = pick_float();
      p.y_re = pick_float();
      p.y_im = pick_float();
      p.last = ($urandom_range(0, 7) == 0);
      send_pair(p);
    end
  endtask

  logic [31:0] coef_cos[9] = '{32'h3F35_04F3, 32'h0000_0000, 32'hBF80_0000, 32'h7F80_0000,
                               32'h0000_0001, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                               32'h3F5D_B3D7};
  logic [31:0] coef_sin[9] = '{32'h3F35_04F3, 32'h3F80_0000, 32'h8000_0000, 32'h0080_0000,
                               32'hFF80_0000, 32'h007F_FFFF, 32'h7FC0_0001, 32'hFF7F_FFFF,
                               32'hBF00_0000};
  logic [31:0] specials[12] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
                                32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000, 32'h3F80_0000};

  initial begin
    pair_t p;
    sb.cos_bits = COS_RESET;
    sb.sin_bits = SIN_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items at reset coefficients and with c = s = 0.7071.
    for (int k = 0; k < 2; k++) begin
      if (k == 1) begin
        write_reg(REG_COS, 32'h3F35_04F3);
        write_reg(REG_SIN, 32'h3F35_04F3);
      end
      for (int i = 0; i < 12; i++) begin
        p.x_re = specials[i];
        p.x_im = specials[(i + 3) % 12];
        p.y_re = specials[(i + 7) % 12];
        p.y_im = specials[(11 - i)];
        p.last = i[0];
        send_pair(p);
      end
    end

    // Random phases; the first third idles lightly, the next heavily, the rest never.
    for (int ph = 0; ph < 9; ph++) begin
      idle_pct = (ph < 3) ? 36 : (ph < 6) ? 63 : 0;
      write_reg(REG_COS, (ph == 8) ? $urandom : coef_cos[ph]);
      write_reg(REG_SIN, (ph == 8) ? $urandom : coef_sin[ph]);
      send_random(150);
    end

    start <= 1'b0;
    while (sb.rotated_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
